/* rtl/core/alert_hysteresis_carousel_core_assert.svh */
// Assertion macros shared by the alert carousel RTL.
// Depends on i_clk and i_rst_n being present in the module that uses them.
`ifndef ALERT_HYSTERESIS_CAROUSEL_CORE_ASSERT_SVH
`define ALERT_HYSTERESIS_CAROUSEL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define AHC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("alert carousel: same-cycle check failed");
// Next-cycle implication, checked while out of reset.
`define AHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("alert carousel: next-cycle check failed");
`else
`define AHC_ASSERT_NOW(label, ante, cons)
`define AHC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/core/ahc_pkg.sv */
// Types, constants and helper functions for the alert carousel.
// No dependencies; used by the interfaces and every module of the block.
package ahc_pkg;

    localparam int TEMP_W  = 9;
    localparam int TIMER_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_ALERTS = 3;
    localparam int IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_ON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_OFF     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_ON     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_OFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_PERIOD  = 3'd4;

    // Register reset values.
    localparam logic signed [TEMP_W-1:0] ENGINE_ON_RST   = 9'sd105;
    localparam logic signed [TEMP_W-1:0] ENGINE_OFF_RST  = 9'sd95;
    localparam logic signed [TEMP_W-1:0] BATTERY_ON_RST  = 9'sd50;
    localparam logic signed [TEMP_W-1:0] BATTERY_OFF_RST = 9'sd45;
    localparam logic [TIMER_W-1:0]       ROTATE_RST      = 16'd3000;

    // Alert codes, which are also the ring positions of the carousel.
    localparam logic [IDX_W-1:0] ALERT_CAN     = 2'd0;
    localparam logic [IDX_W-1:0] ALERT_ENGINE  = 2'd1;
    localparam logic [IDX_W-1:0] ALERT_BATTERY = 2'd2;

    // Active alerts of one item; can sits in bit 0, matching its ring position.
    typedef struct packed {
        logic battery;
        logic engine;
        logic can;
    } t_alerts;

    // Display state handed from the carousel to the top level.
    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             phase;
    } t_disp;

    // One step round the ring CAN, engine, battery, CAN, ...
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        res = (idx >= ALERT_BATTERY) ? ALERT_CAN : idx + 2'd1;
        return res;
    endfunction

    // Next active alert after idx; lands three steps on if none is found.
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                    input t_alerts act);
        logic [NUM_ALERTS-1:0] vec;
        logic [IDX_W-1:0] c1;
        logic [IDX_W-1:0] c2;
        logic [IDX_W-1:0] res;
        vec = act;
        c1 = ring_next(idx);
        c2 = ring_next(c1);
        if (vec[c1]) begin
            res = c1;
        end else if (vec[c2]) begin
            res = c2;
        end else begin
            res = ring_next(c2);
        end
        return res;
    endfunction

endpackage

/* rtl/core/ahc_if.sv */
// Valid/ready channel interfaces for the alert carousel's items.
// Depends on ahc_pkg for field widths.
interface ahc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 bus_error;
    logic signed [ahc_pkg::TEMP_W-1:0]    engine_temp;
    logic signed [ahc_pkg::TEMP_W-1:0]    battery_temp;

    modport source (output valid, bus_error, engine_temp, battery_temp, input ready);
    modport sink   (input valid, bus_error, engine_temp, battery_temp, output ready);
endinterface

interface ahc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         can_alert;
    logic                         engine_alert;
    logic                         battery_alert;
    logic [1:0]                   alert_count;
    logic [ahc_pkg::IDX_W-1:0]    shown_alert;
    logic                         text_visible;

    modport source (output valid, can_alert, engine_alert, battery_alert, alert_count,
                    shown_alert, text_visible, input ready);
    modport sink   (input valid, can_alert, engine_alert, battery_alert, alert_count,
                    shown_alert, text_visible, output ready);
endinterface

/* rtl/core/ahc_hyst.sv */
// Hysteresis latch for one temperature alert.
// Depends on ahc_pkg for the temperature width.
module ahc_hyst (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic signed [ahc_pkg::TEMP_W-1:0] i_temp,
    input  logic signed [ahc_pkg::TEMP_W-1:0] i_on_thr,
    input  logic signed [ahc_pkg::TEMP_W-1:0] i_off_thr,
    output logic                              o_next,
    output logic                              o_alert
);

    logic r_latched;
    logic n_latched;

    // A clear alert sets at or above the on threshold; a set one clears at or below off.
    always_comb begin
        if (r_latched) begin
            n_latched = !(i_temp <= i_off_thr);
        end else begin
            n_latched = (i_temp >= i_on_thr);
        end
    end

    // The latch moves only when an item passes through.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= 1'b0;
        end else if (i_en) begin
            r_latched <= n_latched;
        end
    end

    assign o_next  = n_latched;
    assign o_alert = r_latched;

endmodule

/* rtl/core/ahc_timer.sv */
// Tick counter that fires when its count reaches the period and then restarts.
// Depends on ahc_pkg for the counter width.
module ahc_timer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [ahc_pkg::TIMER_W-1:0]  i_period,
    output logic                         o_fire
);

    logic [ahc_pkg::TIMER_W-1:0] r_elapsed;
    logic [ahc_pkg::TIMER_W-1:0] n_elapsed;
    logic [ahc_pkg::TIMER_W:0]   w_incr;

    // One extra bit so the incremented count never wraps before the compare.
    always_comb begin
        w_incr    = {1'b0, r_elapsed} + {{ahc_pkg::TIMER_W{1'b0}}, 1'b1};
        o_fire    = (w_incr >= {1'b0, i_period});
        n_elapsed = o_fire ? '0 : w_incr[ahc_pkg::TIMER_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
        end else if (i_en) begin
            r_elapsed <= n_elapsed;
        end
    end

endmodule

/* rtl/core/ahc_carousel.sv */
// Carousel of the displayed alert and the blink phase, each driven by a tick timer.
// Depends on ahc_pkg, ahc_timer and the assertion macro header.
`include "alert_hysteresis_carousel_core_assert.svh"
module ahc_carousel (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  ahc_pkg::t_alerts             i_alerts,
    input  logic [ahc_pkg::TIMER_W-1:0]  i_rotate_period,
    input  logic [ahc_pkg::TIMER_W-1:0]  i_blink_period,
    output ahc_pkg::t_disp               o_disp
);

    logic                        w_rotate_fire;
    logic                        w_blink_fire;
    logic [ahc_pkg::IDX_W-1:0]   r_index;
    logic [ahc_pkg::IDX_W-1:0]   n_index;
    logic                        r_phase;

    ahc_timer u_rotate_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (i_en),
        .i_period (i_rotate_period),
        .o_fire   (w_rotate_fire)
    );

    ahc_timer u_blink_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (i_en),
        .i_period (i_blink_period),
        .o_fire   (w_blink_fire)
    );

    // Advance to the next active alert; with none active the index stays put.
    always_comb begin
        if (w_rotate_fire && (i_alerts != '0)) begin
            n_index = ahc_pkg::next_index(r_index, i_alerts);
        end else begin
            n_index = r_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= ahc_pkg::ALERT_CAN;
            r_phase <= 1'b1;
        end else if (i_en) begin
            r_index <= n_index;
            if (w_blink_fire) begin
                r_phase <= !r_phase;
            end
        end
    end

    assign o_disp.index = r_index;
    assign o_disp.phase = r_phase;

    // With no alert active the shown index cannot move.
    `AHC_ASSERT_NEXT(a_idle_index_held, i_en && (i_alerts == '0), r_index == $past(r_index))
    // The index only ever names one of the three alerts.
    `AHC_ASSERT_NOW(a_index_in_ring, 1'b1, r_index != 2'd3)
    // Without an item passing, neither the index nor the blink phase changes.
    `AHC_ASSERT_NEXT(a_hold_when_idle, !i_en, $stable(r_index) && $stable(r_phase))
    // After a move the new index is an alert that was active.
    `AHC_ASSERT_NEXT(a_lands_on_active, i_en && (n_index != r_index),
                     $past(i_alerts[n_index]))

endmodule

/* rtl/core/alert_hysteresis_carousel_core.sv */
// Alert carousel: CAN, engine and battery alerts with hysteresis and a rotating display.
// Top level. Depends on ahc_pkg, ahc_if, ahc_hyst, ahc_carousel and the assertion header.
//
// Use: one input item per millisecond tick on i_item (bus_error, engine_temp,
// battery_temp); one result item per input item on o_result. Thresholds and
// the rotate period are written through i_cfg_we / i_cfg_index / i_cfg_data
// while the block is idle; indexes beyond the rotate period are ignored.
// An item accepted into the input register is evaluated and written to the
// result register once that register is free, and is offered on o_result
// from then on.
// Throughput: one item per cycle while the receiver does not stall; the
// hysteresis compares, the two tick counters and the carousel step are all
// resolved combinationally between the input and the result register.
// Reset (synchronous, active low) restores the register defaults, clears both
// latches, shows the CAN alert and starts with the text visible.
// If the receiver stalls, the result register holds its item and the input
// register takes one more item; i_item.ready falls only when both are full.
`include "alert_hysteresis_carousel_core_assert.svh"
module alert_hysteresis_carousel_core #(
    parameter int unsigned BLINK_HALF_TICKS = 500
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ahc_in_if.sink                            i_item,
    ahc_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [ahc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ahc_pkg::CFG_W-1:0]         i_cfg_data
);

    // Configuration registers.
    logic signed [ahc_pkg::TEMP_W-1:0] r_engine_on;
    logic signed [ahc_pkg::TEMP_W-1:0] r_engine_off;
    logic signed [ahc_pkg::TEMP_W-1:0] r_battery_on;
    logic signed [ahc_pkg::TEMP_W-1:0] r_battery_off;
    logic [ahc_pkg::TIMER_W-1:0]       r_rotate_period;

    // Input register.
    logic                              r_s1_valid;
    logic                              r_s1_bus_error;
    logic signed [ahc_pkg::TEMP_W-1:0] r_s1_engine_temp;
    logic signed [ahc_pkg::TEMP_W-1:0] r_s1_battery_temp;

    // Result register.
    logic                              r_out_valid;
    logic                              r_out_can;
    logic [1:0]                        r_out_count;

    logic             w_out_free;
    logic             w_advance;
    logic             w_engine_next;
    logic             w_battery_next;
    logic             w_engine_alert;
    logic             w_battery_alert;
    logic [1:0]       w_count;
    ahc_pkg::t_alerts w_alerts;
    ahc_pkg::t_disp   w_disp;

    // Configuration write decode.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engine_on     <= ahc_pkg::ENGINE_ON_RST;
            r_engine_off    <= ahc_pkg::ENGINE_OFF_RST;
            r_battery_on    <= ahc_pkg::BATTERY_ON_RST;
            r_battery_off   <= ahc_pkg::BATTERY_OFF_RST;
            r_rotate_period <= ahc_pkg::ROTATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ahc_pkg::CFG_ENGINE_ON:     r_engine_on     <= i_cfg_data[ahc_pkg::TEMP_W-1:0];
                ahc_pkg::CFG_ENGINE_OFF:    r_engine_off    <= i_cfg_data[ahc_pkg::TEMP_W-1:0];
                ahc_pkg::CFG_BATTERY_ON:    r_battery_on    <= i_cfg_data[ahc_pkg::TEMP_W-1:0];
                ahc_pkg::CFG_BATTERY_OFF:   r_battery_off   <= i_cfg_data[ahc_pkg::TEMP_W-1:0];
                ahc_pkg::CFG_ROTATE_PERIOD: r_rotate_period <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Handshake: the result register frees up when empty or taken this cycle.
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_advance    = r_s1_valid && w_out_free;
    assign i_item.ready = !r_s1_valid || w_out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1_bus_error    <= i_item.bus_error;
            r_s1_engine_temp  <= i_item.engine_temp;
            r_s1_battery_temp <= i_item.battery_temp;
        end
    end

    ahc_hyst u_engine_hyst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_temp    (r_s1_engine_temp),
        .i_on_thr  (r_engine_on),
        .i_off_thr (r_engine_off),
        .o_next    (w_engine_next),
        .o_alert   (w_engine_alert)
    );

    ahc_hyst u_battery_hyst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_temp    (r_s1_battery_temp),
        .i_on_thr  (r_battery_on),
        .i_off_thr (r_battery_off),
        .o_next    (w_battery_next),
        .o_alert   (w_battery_alert)
    );

    // This item's alerts and their count.
    always_comb begin
        w_alerts.can     = r_s1_bus_error;
        w_alerts.engine  = w_engine_next;
        w_alerts.battery = w_battery_next;
        w_count = {1'b0, w_alerts.can} + {1'b0, w_alerts.engine} + {1'b0, w_alerts.battery};
    end

    ahc_carousel u_carousel (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_advance),
        .i_alerts        (w_alerts),
        .i_rotate_period (r_rotate_period),
        .i_blink_period  (ahc_pkg::TIMER_W'(BLINK_HALF_TICKS)),
        .o_disp          (w_disp)
    );

    // Result register; the latches and carousel state load on the same edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_can   <= r_s1_bus_error;
            r_out_count <= w_count;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.can_alert     = r_out_can;
    assign o_result.engine_alert  = w_engine_alert;
    assign o_result.battery_alert = w_battery_alert;
    assign o_result.alert_count   = r_out_count;
    assign o_result.shown_alert   = w_disp.index;
    assign o_result.text_visible  = w_disp.phase;

    // Both registers full and the receiver stalled: no further item may enter.
    `AHC_ASSERT_NOW(a_full_blocks_input, r_s1_valid && r_out_valid && !o_result.ready,
                    !i_item.ready)
    // The count shown always matches the alert flags shown beside it.
    `AHC_ASSERT_NOW(a_count_matches, r_out_valid,
                    r_out_count == 2'($countones({r_out_can, w_engine_alert, w_battery_alert})))
    // An item evaluated this cycle is offered on the result channel next cycle.
    `AHC_ASSERT_NEXT(a_advance_fills_output, w_advance, r_out_valid)

endmodule

/* sim/alert_hysteresis_carousel_core_checker.sv */
// Checker for the alert carousel: watches the tick, result and configuration ports.
// Keeps its own model of the alerts, carousel and blink timer; depends on ahc_pkg and ahc_if.
`timescale 1ns / 100ps
module alert_hysteresis_carousel_core_checker #(
    parameter int unsigned BLINK_HALF_TICKS = 500
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ahc_in_if                                 tick_ch,
    ahc_out_if                                res_ch,
    input  logic                              i_cfg_we,
    input  logic [ahc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ahc_pkg::CFG_W-1:0]         i_cfg_data,
    output int                                o_errors,
    output int                                o_pending
);

    // Everything one result item carries.
    typedef struct packed {
        logic                      can;
        logic                      engine;
        logic                      battery;
        logic [1:0]                count;
        logic [ahc_pkg::IDX_W-1:0] shown;
        logic                      visible;
    } t_status;

    // Copy of the registers.
    logic signed [ahc_pkg::TEMP_W-1:0] eng_on;
    logic signed [ahc_pkg::TEMP_W-1:0] eng_off;
    logic signed [ahc_pkg::TEMP_W-1:0] bat_on;
    logic signed [ahc_pkg::TEMP_W-1:0] bat_off;
    logic [ahc_pkg::TIMER_W-1:0]       rot_period;

    // Copy of the block's state.
    logic                              eng_latched;
    logic                              bat_latched;
    logic [ahc_pkg::IDX_W-1:0]         disp_idx;
    logic [ahc_pkg::TIMER_W-1:0]       rot_elapsed;
    logic [ahc_pkg::TIMER_W-1:0]       blink_elapsed;
    logic                              blink_phase;

    t_status status_q[$];
    int      err_count = 0;

    assign o_errors = err_count;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string fname, input int got_v, input int want_v);
        if (got_v != want_v) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", fname, got_v, want_v));
        end
    endtask

    // Works out one tick: hysteresis first, then the carousel step, then the blink timer.
    task automatic advance_tick(input logic be, input logic signed [ahc_pkg::TEMP_W-1:0] et,
                                input logic signed [ahc_pkg::TEMP_W-1:0] bt,
                                output t_status st);
        logic [ahc_pkg::TIMER_W:0]      rot_next;
        logic [ahc_pkg::TIMER_W:0]      blink_next;
        logic [ahc_pkg::NUM_ALERTS-1:0] act;
        logic [1:0]                     cnt;
        logic [ahc_pkg::IDX_W-1:0]      idx;
        if (!eng_latched) begin
            eng_latched = (et >= eng_on);
        end else begin
            eng_latched = !(et <= eng_off);
        end
        if (!bat_latched) begin
            bat_latched = (bt >= bat_on);
        end else begin
            bat_latched = !(bt <= bat_off);
        end
        act = {bat_latched, eng_latched, be};
        cnt = {1'b0, act[0]} + {1'b0, act[1]} + {1'b0, act[2]};

        // The carousel moves on to the next active alert; with none active it stays.
        rot_next = {1'b0, rot_elapsed} + 1'b1;
        if (rot_next >= {1'b0, rot_period}) begin
            rot_elapsed = '0;
            if (cnt != 2'd0) begin
                idx = disp_idx;
                for (int k = 0; k < ahc_pkg::NUM_ALERTS; k++) begin
                    idx = (idx >= ahc_pkg::ALERT_BATTERY) ? ahc_pkg::ALERT_CAN : idx + 1'b1;
                    if (act[idx]) break;
                end
                disp_idx = idx;
            end
        end else begin
            rot_elapsed = rot_next[ahc_pkg::TIMER_W-1:0];
        end

        blink_next = {1'b0, blink_elapsed} + 1'b1;
        if (blink_next >= BLINK_HALF_TICKS) begin
            blink_elapsed = '0;
            blink_phase   = ~blink_phase;
        end else begin
            blink_elapsed = blink_next[ahc_pkg::TIMER_W-1:0];
        end

        st.can     = act[0];
        st.engine  = act[1];
        st.battery = act[2];
        st.count   = cnt;
        st.shown   = disp_idx;
        st.visible = blink_phase;
    endtask

    // Sample all ports at the clock edge.
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (!i_rst_n) begin
            eng_on        = ahc_pkg::ENGINE_ON_RST;
            eng_off       = ahc_pkg::ENGINE_OFF_RST;
            bat_on        = ahc_pkg::BATTERY_ON_RST;
            bat_off       = ahc_pkg::BATTERY_OFF_RST;
            rot_period    = ahc_pkg::ROTATE_RST;
            eng_latched   = 1'b0;
            bat_latched   = 1'b0;
            disp_idx      = ahc_pkg::ALERT_CAN;
            rot_elapsed   = '0;
            blink_elapsed = '0;
            blink_phase   = 1'b1;
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ahc_pkg::CFG_ENGINE_ON:
                        eng_on = i_cfg_data[ahc_pkg::TEMP_W-1:0];
                    ahc_pkg::CFG_ENGINE_OFF:
                        eng_off = i_cfg_data[ahc_pkg::TEMP_W-1:0];
                    ahc_pkg::CFG_BATTERY_ON:
                        bat_on = i_cfg_data[ahc_pkg::TEMP_W-1:0];
                    ahc_pkg::CFG_BATTERY_OFF:
                        bat_off = i_cfg_data[ahc_pkg::TEMP_W-1:0];
                    ahc_pkg::CFG_ROTATE_PERIOD:
                        rot_period = i_cfg_data[ahc_pkg::TIMER_W-1:0];
                    default: ;
                endcase
            end
            if (tick_ch.valid && tick_ch.ready) begin
                advance_tick(tick_ch.bus_error, tick_ch.engine_temp, tick_ch.battery_temp,
                             want);
                status_q.push_back(want);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.can     = res_ch.can_alert;
                got.engine  = res_ch.engine_alert;
                got.battery = res_ch.battery_alert;
                got.count   = res_ch.alert_count;
                got.shown   = res_ch.shown_alert;
                got.visible = res_ch.text_visible;
                if (status_q.size() == 0) begin
                    report_mismatch("result item arrived with no tick outstanding");
                end else begin
                    want = status_q.pop_front();
                    check_field("can_alert", got.can, want.can);
                    check_field("engine_alert", got.engine, want.engine);
                    check_field("battery_alert", got.battery, want.battery);
                    check_field("alert_count", got.count, want.count);
                    check_field("shown_alert", got.shown, want.shown);
                    check_field("text_visible", got.visible, want.visible);
                end
            end
        end
        o_pending <= status_q.size();
    end

endmodule

/* sim/alert_hysteresis_carousel_core_tb.sv */
// Testbench top for the alert carousel: clock, reset, tick stimulus and result back-pressure.
// Depends on ahc_pkg, ahc_if, the core and alert_hysteresis_carousel_core_checker.
`timescale 1ns / 100ps
module alert_hysteresis_carousel_core_tb;

    localparam int unsigned BLINK_HALF = 500;
    localparam int          RAND_PHASES = 8;
    localparam int          PHASE_TICKS = 92;
    localparam int          HOLD_CYCLES = 300;

    // Indexes past the last register, which the block must ignore.
    localparam logic [ahc_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [ahc_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [ahc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ahc_pkg::CFG_W-1:0]     i_cfg_data;
    int                            err_total;
    int                            ticks_pending;

    ahc_in_if  tick_ch ();
    ahc_out_if res_ch ();

    // Stimulus state shared with the receiver.
    bit idle_en   = 1'b1;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int ticks_sent = 0;

    // Thresholds as last written, used to aim temperatures at the switching points.
    int eng_on_now  = 105;
    int eng_off_now = 95;
    int bat_on_now  = 50;
    int bat_off_now = 45;

    alert_hysteresis_carousel_core #(
        .BLINK_HALF_TICKS(BLINK_HALF)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (tick_ch),
        .o_result    (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    alert_hysteresis_carousel_core_checker #(
        .BLINK_HALF_TICKS(BLINK_HALF)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .tick_ch     (tick_ch),
        .res_ch      (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (err_total),
        .o_pending   (ticks_pending)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #5000000;
        $display("Timeout waiting for the block");
        $display("alert_hysteresis_carousel_core test failed");
        $finish;
    end

    // Offers one tick item and returns at the edge where it is accepted.
    task automatic send_tick(input logic be, input int et, input int bt);
        logic [ahc_pkg::TEMP_W-1:0] et_bits;
        logic [ahc_pkg::TEMP_W-1:0] bt_bits;
        et_bits = et[ahc_pkg::TEMP_W-1:0];
        bt_bits = bt[ahc_pkg::TEMP_W-1:0];
        if (idle_en && $urandom_range(0, 4) == 0) begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.bus_error    <= be;
        tick_ch.engine_temp  <= et_bits;
        tick_ch.battery_temp <= bt_bits;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        ticks_sent++;
    endtask

    // Stops offering and waits until every result has been taken.
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (ticks_pending != 0) @(posedge i_clk);
    endtask

    // Write enable stays high across a batch of writes; cfg_end drops it.
    task automatic cfg_write(input logic [ahc_pkg::CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[ahc_pkg::CFG_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic cfg_end();
        i_cfg_we <= 1'b0;
    endtask

    // Threshold write with random bits above the 9-bit field.
    task automatic cfg_threshold(input logic [ahc_pkg::CFG_IDX_W-1:0] idx, input int value);
        int junk;
        junk = $urandom_range(0, 127);
        cfg_write(idx, (value & 'h1FF) | (junk << ahc_pkg::TEMP_W));
    endtask

    task automatic set_thresholds(input int e_on, input int e_off, input int b_on,
                                  input int b_off);
        cfg_threshold(ahc_pkg::CFG_ENGINE_ON, e_on);
        cfg_threshold(ahc_pkg::CFG_ENGINE_OFF, e_off);
        cfg_threshold(ahc_pkg::CFG_BATTERY_ON, b_on);
        cfg_threshold(ahc_pkg::CFG_BATTERY_OFF, b_off);
        eng_on_now  = e_on;
        eng_off_now = e_off;
        bat_on_now  = b_on;
        bat_off_now = b_off;
    endtask

    // Temperature mostly close to one of the two switching points.
    function automatic int pick_temp(input int on_t, input int off_t);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = on_t + $urandom_range(0, 8) - 4;
            4, 5, 6, 7: v = off_t + $urandom_range(0, 8) - 4;
            8:          v = $urandom_range(0, 511) - 256;
            default:    v = $urandom_range(0, 1) ? 255 : -256;
        endcase
        if (v > 255) v = 255;
        if (v < -256) v = -256;
        return v;
    endfunction

    // Receiver: random stalls, one long hold-off on request.
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                res_ch.ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int period;
        int wait_cycles;
        tick_ch.valid        <= 1'b0;
        tick_ch.bus_error    <= 1'b0;
        tick_ch.engine_temp  <= '0;
        tick_ch.battery_temp <= '0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= ahc_pkg::CFG_ENGINE_ON;
        i_cfg_data           <= '0;
        i_rst_n              <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: extremes and the exact switching points.
        send_tick(1'b0, 0, 0);
        send_tick(1'b1, -256, -256);
        send_tick(1'b0, 255, 255);
        send_tick(1'b0, 96, 46);
        send_tick(1'b1, 95, 45);
        send_tick(1'b0, 104, 49);
        send_tick(1'b1, 105, 50);
        send_tick(1'b0, 255, -256);
        send_tick(1'b1, -256, 255);
        drain_results();

        // Rotation every tick; writes to unused indexes must change nothing.
        cfg_write(ahc_pkg::CFG_ROTATE_PERIOD, 1);
        cfg_write(CFG_SPARE_FIRST, 'h0000);
        cfg_write(CFG_SPARE_LAST, 'hFFFF);
        cfg_end();
        send_tick(1'b0, -256, -256);
        send_tick(1'b0, 0, 0);
        send_tick(1'b0, 110, 0);
        send_tick(1'b0, 100, 0);
        send_tick(1'b0, 0, 0);
        send_tick(1'b1, 200, 100);
        send_tick(1'b1, 200, 100);
        send_tick(1'b0, 0, 60);
        drain_results();

        // Zero rotate period and crossed thresholds.
        cfg_write(ahc_pkg::CFG_ROTATE_PERIOD, 0);
        set_thresholds(-10, 100, 255, -256);
        cfg_end();
        send_tick(1'b0, 50, 255);
        send_tick(1'b1, 50, 0);
        send_tick(1'b0, -20, -256);
        send_tick(1'b1, 101, 254);
        send_tick(1'b0, -256, 255);
        drain_results();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       period = 0;
                1:       period = 65535;
                2:       period = 3000;
                3:       period = $urandom_range(0, 65535);
                default: period = $urandom_range(1, 40);
            endcase
            if (ph == 0) begin
                set_thresholds(255, -256, -256, 255);
            end else if (ph == 1) begin
                set_thresholds(-256, 255, 255, -256);
                period = 65535;
            end else begin
                set_thresholds($urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                               $urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256);
            end
            cfg_write(ahc_pkg::CFG_ROTATE_PERIOD, period);
            cfg_end();
            idle_en = (ph < RAND_PHASES - 1);
            for (int k = 0; k < PHASE_TICKS; k++) begin
                if (ph == 3 && k == 20) hold_req = 1'b1;
                send_tick($urandom_range(0, 1), pick_temp(eng_on_now, eng_off_now),
                          pick_temp(bat_on_now, bat_off_now));
            end
            drain_results();
        end

        // Final settle with a bound.
        wait_cycles = 0;
        while (ticks_pending != 0 && wait_cycles < 2000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);

        $display("Summary: %0d ticks over %0d register settings, with hysteresis edges,",
                 ticks_sent, RAND_PHASES + 3);
        $display("zero and maximum rotate periods, crossed thresholds and a long result stall.");
        if (err_total == 0 && ticks_pending == 0) begin
            $display("alert_hysteresis_carousel_core test passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", err_total, ticks_pending);
            $display("alert_hysteresis_carousel_core test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ahc_pkg.sv
rtl/core/ahc_if.sv
rtl/core/ahc_hyst.sv
rtl/core/ahc_timer.sv
rtl/core/ahc_carousel.sv
rtl/core/alert_hysteresis_carousel_core.sv
sim/alert_hysteresis_carousel_core_checker.sv
sim/alert_hysteresis_carousel_core_tb.sv
